// File: hdl/chained_hash_set_defines.svh
// Assertion macros shared by the checker of the chained hash set.
// Holds no logic; included by the files that assert.
`ifndef CHAINED_HASH_SET_DEFINES_SVH
`define CHAINED_HASH_SET_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/chs_pkg.sv
// Package of the chained hash set: widths, default sizes, opcode and state types.
// Used by every module of the block; depends on nothing.
package chs_pkg;

    localparam int KEY_W        = 32;
    localparam int DEF_BUCKETS  = 1024;
    localparam int DEF_ENTRIES  = 1024;
    // Register stages of the remainder unit: reciprocal multiply, then back-multiply.
    localparam int REM_STEPS    = 2;
    localparam int STEP_CNT_W   = $clog2(REM_STEPS + 1);

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_HEAD,
        BS_WALK
    } back_state_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

// File: hdl/chs_front.sv
// Front end of the chained hash set: accepts items and computes the bucket.
// The bucket is the non-negative remainder of the signed key, from a reciprocal multiply.
// Depends on chs_pkg.
module chs_front
    import chs_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int BW      = $clog2(BUCKETS)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  op_t                     opcode,
    input  logic signed [KEY_W-1:0] key,
    input  back_status_t            status,
    output logic                    q_push,
    input  logic                    q_full,
    output op_t                     q_op,
    output logic [KEY_W-1:0]        q_key,
    output logic [BW-1:0]           q_bucket
);

    localparam int RW = BW + 1;
    localparam logic [RW-1:0] BMOD = RW'(BUCKETS);
    // Scaled reciprocal of the modulus; the quotient it gives is low by at most one.
    localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / 64'(BUCKETS));

    logic                  busy_reg, busy_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    op_t                   op_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [KEY_W-1:0]      mag_reg;
    logic [KEY_W-1:0]      quot_reg, quot_next;
    logic [RW-1:0]         rem_reg, rem_next;
    logic [RW-1:0]         rem_fix;
    logic                  done;
    logic                  accept;
    logic [RW-1:0]         bucket_full;

    assign done   = busy_reg && (cnt_reg == STEP_CNT_W'(REM_STEPS));
    assign q_push = done && !q_full;
    // A finished item can leave in the same cycle that the next one comes in.
    assign full   = status.clearing || (busy_reg && !q_push);
    assign accept = push && !full;

    // The first stage estimates the quotient of the magnitude; the second takes the
    // remainder in its low bits, where it lies below twice the modulus.
    always_comb
    begin
        quot_next = KEY_W'(({{KEY_W{1'b0}}, mag_reg} * {{KEY_W{1'b0}}, RECIP}) >> KEY_W);
        rem_next  = RW'(mag_reg) - RW'(quot_reg) * BMOD;
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (q_push)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && !done)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (accept)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            key_reg <= key;
            mag_reg <= key[KEY_W-1] ? KEY_W'(-key) : key;
        end
        else if (busy_reg && !done)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign rem_fix = (rem_reg >= BMOD) ? (rem_reg - BMOD) : rem_reg;
    // A negative key with a nonzero remainder maps to the modulus minus it.
    assign bucket_full = (key_reg[KEY_W-1] && (rem_fix != '0)) ? (BMOD - rem_fix) : rem_fix;
    assign q_op        = op_reg;
    assign q_key       = key_reg;
    assign q_bucket    = bucket_full[BW-1:0];

endmodule

// File: hdl/chs_queue.sv
// Two-entry queue that decouples the front end from the table engine.
// Depends on chs_pkg for the default width.
module chs_queue
    import chs_pkg::*;
#(
    parameter int W = KEY_W + 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic         empty,
    output logic [W-1:0] rdata
);

    logic [W-1:0] slot_reg [2];
    logic         wptr_reg, wptr_next;
    logic         rptr_reg, rptr_next;
    logic [1:0]   count_reg, count_next;
    logic         do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg ^ do_push;
        rptr_next  = rptr_reg ^ do_pop;
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// File: hdl/chs_back.sv
// Table engine of the chained hash set: bucket head memory, entry pool, chain walker.
// Holds the result register seen on the output ports. Depends on chs_pkg.
module chs_back
    import chs_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int ENTRIES = DEF_ENTRIES,
    parameter int BW      = $clog2(BUCKETS),
    parameter int EW      = $clog2(ENTRIES)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    output logic             q_pop,
    input  op_t              q_op,
    input  logic [KEY_W-1:0] q_key,
    input  logic [BW-1:0]    q_bucket,
    output back_status_t     status,
    output logic             empty,
    input  logic             pop,
    output logic             found,
    output logic             pool_full
);

    localparam int HW = EW + 1;
    localparam int NW = KEY_W + EW + 1;

    // Head word: {valid, pointer}. Entry word: {key, next valid, next pointer}.
    logic [HW-1:0] head_mem [BUCKETS];
    logic [NW-1:0] entry_mem [ENTRIES];

    back_state_t      state_reg, state_next;
    logic [BW-1:0]    clr_reg, clr_next;
    logic [EW:0]      used_reg, used_next;
    op_t              op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [BW-1:0]    bkt_reg;
    logic [HW-1:0]    head_q;
    logic [NW-1:0]    ent_q;
    logic             out_valid_reg, out_valid_next;
    logic             found_reg, full_reg;

    logic             head_rd_en, head_wr_en;
    logic [BW-1:0]    head_rd_addr, head_wr_addr;
    logic [HW-1:0]    head_wr_data;
    logic             ent_rd_en, ent_wr_en;
    logic [EW-1:0]    ent_rd_addr;
    logic             res_ok, res_valid, res_found, res_full;
    logic             pool_is_full;

    assign res_ok       = !out_valid_reg || pop;
    assign pool_is_full = (used_reg == (EW + 1)'(ENTRIES));

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        used_next    = used_reg;
        q_pop        = 1'b0;
        head_rd_en   = 1'b0;
        head_rd_addr = q_bucket;
        head_wr_en   = 1'b0;
        head_wr_addr = bkt_reg;
        head_wr_data = {1'b1, used_reg[EW-1:0]};
        ent_rd_en    = 1'b0;
        ent_rd_addr  = head_q[EW-1:0];
        ent_wr_en    = 1'b0;
        res_valid    = 1'b0;
        res_found    = 1'b0;
        res_full     = 1'b0;
        case (state_reg)
            BS_CLEAR:
            begin
                head_wr_en   = 1'b1;
                head_wr_addr = clr_reg;
                head_wr_data = '0;
                clr_next     = clr_reg + 1'b1;
                if (clr_reg == BW'(BUCKETS - 1))
                begin
                    state_next = BS_IDLE;
                end
            end
            BS_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    head_rd_en = 1'b1;
                    state_next = BS_HEAD;
                end
            end
            BS_HEAD:
            begin
                if (op_reg == OP_INSERT)
                begin
                    if (res_ok)
                    begin
                        res_valid  = 1'b1;
                        res_full   = pool_is_full;
                        state_next = BS_IDLE;
                        if (!pool_is_full)
                        begin
                            ent_wr_en  = 1'b1;
                            head_wr_en = 1'b1;
                            used_next  = used_reg + 1'b1;
                        end
                    end
                end
                else if (!head_q[EW])
                begin
                    if (res_ok)
                    begin
                        res_valid  = 1'b1;
                        state_next = BS_IDLE;
                    end
                end
                else
                begin
                    ent_rd_en  = 1'b1;
                    state_next = BS_WALK;
                end
            end
            BS_WALK:
            begin
                ent_rd_addr = ent_q[EW-1:0];
                if (ent_q[NW-1 -: KEY_W] == key_reg)
                begin
                    if (res_ok)
                    begin
                        res_valid  = 1'b1;
                        res_found  = 1'b1;
                        state_next = BS_IDLE;
                    end
                end
                else if (!ent_q[EW])
                begin
                    if (res_ok)
                    begin
                        res_valid  = 1'b1;
                        state_next = BS_IDLE;
                    end
                end
                else
                begin
                    ent_rd_en = 1'b1;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_CLEAR;
            clr_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg  <= q_op;
            key_reg <= q_key;
            bkt_reg <= q_bucket;
        end
        if (res_valid)
        begin
            found_reg <= res_found;
            full_reg  <= res_full;
        end
    end

    // Bucket head memory, one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (head_wr_en)
        begin
            head_mem[head_wr_addr] <= head_wr_data;
        end
        if (head_rd_en)
        begin
            head_q <= head_mem[head_rd_addr];
        end
    end

    // Entry pool; a new entry links to the old chain head.
    always_ff @(posedge clk)
    begin
        if (ent_wr_en)
        begin
            entry_mem[used_reg[EW-1:0]] <= {key_reg, head_q};
        end
        if (ent_rd_en)
        begin
            ent_q <= entry_mem[ent_rd_addr];
        end
    end

    assign status.clearing = (state_reg == BS_CLEAR);
    assign empty           = !out_valid_reg;
    assign found           = found_reg;
    assign pool_full       = full_reg;

endmodule

// File: hdl/chained_hash_set.sv
// Chained hash set. Each item passes the bucket remainder unit, then the queue; the table
// engine ends an insert or a query of an empty bucket at the head read and walks a query's
// chain one entry at a time (one entry pool read per cycle). The front end takes a new item
// only as the last one leaves it; the table engine pops the next once it is back in idle.
// After reset a pass clears the BUCKETS head entries, one per cycle, while full stays high.
// Depends on chs_pkg and the modules below.
module chained_hash_set
    import chs_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic                    opcode,
    input  logic signed [KEY_W-1:0] key,
    output logic                    empty,
    input  logic                    pop,
    output logic                    found,
    output logic                    pool_full
);

    localparam int BW = $clog2(BUCKETS);
    localparam int EW = $clog2(ENTRIES);
    localparam int QW = 1 + KEY_W + BW;

    back_status_t     status;
    logic             fq_push, fq_full, bq_pop, bq_empty;
    op_t              f_op, b_op;
    logic [KEY_W-1:0] f_key, b_key;
    logic [BW-1:0]    f_bucket, b_bucket;
    logic [QW-1:0]    q_wdata, q_rdata;

    chs_front #(
        .BUCKETS (BUCKETS),
        .BW      (BW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .opcode   (op_t'(opcode)),
        .key      (key),
        .status   (status),
        .q_push   (fq_push),
        .q_full   (fq_full),
        .q_op     (f_op),
        .q_key    (f_key),
        .q_bucket (f_bucket)
    );

    assign q_wdata = {f_op, f_key, f_bucket};

    chs_queue #(
        .W (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .full  (fq_full),
        .wdata (q_wdata),
        .pop   (bq_pop),
        .empty (bq_empty),
        .rdata (q_rdata)
    );

    assign b_op     = op_t'(q_rdata[QW-1]);
    assign b_key    = q_rdata[QW-2 -: KEY_W];
    assign b_bucket = q_rdata[BW-1:0];

    chs_back #(
        .BUCKETS (BUCKETS),
        .ENTRIES (ENTRIES),
        .BW      (BW),
        .EW      (EW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (bq_empty),
        .q_pop     (bq_pop),
        .q_op      (b_op),
        .q_key     (b_key),
        .q_bucket  (b_bucket),
        .status    (status),
        .empty     (empty),
        .pop       (pop),
        .found     (found),
        .pool_full (pool_full)
    );

endmodule

// File: hdl/chs_checker.sv
// Port-level checker of the chained hash set, bound to the top level.
// Depends on chained_hash_set_defines.svh for its assertion macros.
`include "chained_hash_set_defines.svh"

module chs_checker
    import chs_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    push,
    input logic                    full,
    input logic                    empty,
    input logic                    pop,
    input logic                    found,
    input logic                    pool_full
);

    // A result is never both a lookup hit and a dropped insert.
    `CHS_ASSERT_SAME(a_excl_flags, clk, rst_n, !empty, !(found && pool_full), "found and pool_full both set")
    // The front end holds one item while it computes the bucket.
    `CHS_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, push && !full, full, "input ready right after a transfer")
    // A waiting result is not dropped or altered.
    `CHS_ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop, !empty && $stable(found) && $stable(pool_full), "waiting result changed")

endmodule

bind chained_hash_set chs_checker u_chs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .found     (found),
    .pool_full (pool_full)
);
